// ----- rtl/sip24_pkg.sv -----
// Shared types, constants and round functions for the SipHash-2-4 stream hasher.
package sip24_pkg;

   localparam int unsigned WORD_WIDTH     = 64;
   localparam int unsigned COUNT_WIDTH    = 4;
   localparam int unsigned LEN_WIDTH      = 8;
   localparam int unsigned BYTES_PER_WORD = 8;
   localparam int unsigned LEN_SHIFT      = 56;
   localparam int unsigned CSR_IDX_WIDTH  = 1;

   // Initialization constants ("somepseudorandomlygeneratedbytes")
   localparam logic [WORD_WIDTH-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_WIDTH-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_WIDTH-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_WIDTH-1:0] SIP_C3 = 64'h7465646279746573;
   localparam logic [WORD_WIDTH-1:0] FINAL_XOR = 64'h00000000000000ff;

   // Rotation amounts of one round
   localparam int unsigned ROT_A = 13;
   localparam int unsigned ROT_B = 32;
   localparam int unsigned ROT_C = 16;
   localparam int unsigned ROT_D = 21;
   localparam int unsigned ROT_E = 17;

   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(BYTES_PER_WORD);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_KEY_LOW  = 1'b0,
      CSR_KEY_HIGH = 1'b1
   } sip24_csr_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] lane_zero;
      logic [WORD_WIDTH-1:0] lane_one;
      logic [WORD_WIDTH-1:0] lane_two;
      logic [WORD_WIDTH-1:0] lane_three;
   } sip24_lanes_type;

   function automatic logic [WORD_WIDTH-1:0] rotl(input logic [WORD_WIDTH-1:0] x,
                                                  input int unsigned r);
      return (x << r) | (x >> (WORD_WIDTH - r));
   endfunction

   // One add-rotate-xor round over the four lanes
   function automatic sip24_lanes_type sip_round(input sip24_lanes_type s);
      sip24_lanes_type t;
      t = s;
      t.lane_zero  = t.lane_zero + t.lane_one;
      t.lane_one   = rotl(t.lane_one, ROT_A) ^ t.lane_zero;
      t.lane_zero  = rotl(t.lane_zero, ROT_B);
      t.lane_two   = t.lane_two + t.lane_three;
      t.lane_three = rotl(t.lane_three, ROT_C) ^ t.lane_two;
      t.lane_zero  = t.lane_zero + t.lane_three;
      t.lane_three = rotl(t.lane_three, ROT_D) ^ t.lane_zero;
      t.lane_two   = t.lane_two + t.lane_one;
      t.lane_one   = rotl(t.lane_one, ROT_E) ^ t.lane_two;
      t.lane_two   = rotl(t.lane_two, ROT_B);
      return t;
   endfunction

   function automatic sip24_lanes_type sip_two_rounds(input sip24_lanes_type s);
      return sip_round(sip_round(s));
   endfunction

   // Absorb one 64-bit block with two compression rounds
   function automatic sip24_lanes_type sip_absorb(input sip24_lanes_type s,
                                                  input logic [WORD_WIDTH-1:0] m);
      sip24_lanes_type t;
      t = s;
      t.lane_three = t.lane_three ^ m;
      t = sip_two_rounds(t);
      t.lane_zero = t.lane_zero ^ m;
      return t;
   endfunction

endpackage

// ----- rtl/siphash_2_4_stream.sv -----
// Top level of the SipHash-2-4 stream hasher: absorb stage and finalization pipeline.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_message_word, req_byte_count, req_last
//  rsp      out        rsp_valid/rsp_ready  rsp_hash_value
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request is taken per cycle unless a last request in the request register
// waits on finalization. That register feeds the absorb stage, whose two rounds
// before the lane registers are combinational. A last request enters a
// three-stage finalization pipeline (block absorb, then two times two rounds).
// Each stage only stalls when the stage after it is full and held; csr_ready is
// always high. Reset clears all valid flags, the keys, in_msg_ff and len_ff.
module siphash_2_4_stream
   import sip24_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [WORD_WIDTH-1:0]    req_message_word,
   input  logic [COUNT_WIDTH-1:0]   req_byte_count,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [WORD_WIDTH-1:0]    rsp_hash_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]    csr_data
);

   // Key registers
   logic [WORD_WIDTH-1:0] key_low_ff;
   logic [WORD_WIDTH-1:0] key_high_ff;

   // Request register
   logic                   s0_valid_ff;
   logic [WORD_WIDTH-1:0]  s0_word_ff;
   logic [COUNT_WIDTH-1:0] s0_count_ff;
   logic                   s0_last_ff;

   // Running message state
   sip24_lanes_type        lane_ff, lane_in;
   logic [LEN_WIDTH-1:0]   len_ff, len_in;
   logic                   in_msg_ff;

   // Finalization pipeline
   logic                   f1_valid_ff, f2_valid_ff, f3_valid_ff;
   sip24_lanes_type        f1_lane_ff, f2_lane_ff, f3_lane_ff;
   sip24_lanes_type        f1_lane_in, f2_lane_in, f3_lane_in;
   logic [WORD_WIDTH-1:0]  f1_block_ff, f1_block_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [WORD_WIDTH-1:0]  rsp_hash_ff, rsp_hash_in;

   // Stage readiness, back to front
   logic out_ready, f3_ready, f2_ready, f1_ready, s0_ready, s0_fire;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign f3_ready  = !f3_valid_ff || out_ready;
   assign f2_ready  = !f2_valid_ff || f3_ready;
   assign f1_ready  = !f1_valid_ff || f2_ready;
   assign s0_ready  = !s0_valid_ff || !s0_last_ff || f1_ready;
   assign s0_fire   = s0_valid_ff && (!s0_last_ff || f1_ready);

   assign req_ready      = s0_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign csr_ready      = 1'b1;

   // Absorb stage: load lanes at message start, absorb full words, build final block
   sip24_lanes_type        start_lane;
   logic [LEN_WIDTH-1:0]   start_len;
   logic [COUNT_WIDTH-1:0] count_sat;
   logic                   full_word;
   logic [WORD_WIDTH-1:0]  tail_bytes;

   always_comb begin
      if (in_msg_ff) begin
         start_lane = lane_ff;
         start_len  = len_ff;
      end else begin
         start_lane.lane_zero  = SIP_C0 ^ key_low_ff;
         start_lane.lane_one   = SIP_C1 ^ key_high_ff;
         start_lane.lane_two   = SIP_C2 ^ key_low_ff;
         start_lane.lane_three = SIP_C3 ^ key_high_ff;
         start_len             = '0;
      end

      count_sat = (s0_count_ff > FULL_COUNT) ? FULL_COUNT : s0_count_ff;
      full_word = !s0_last_ff || (count_sat == FULL_COUNT);

      // keep only the bytes below the count
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         tail_bytes[b*8 +: 8] = (COUNT_WIDTH'(b) < count_sat) ? s0_word_ff[b*8 +: 8] : 8'h00;
      end

      if (full_word) begin
         lane_in = sip_absorb(start_lane, s0_word_ff);
         len_in  = start_len + LEN_WIDTH'(BYTES_PER_WORD);
         f1_block_in = '0;
      end else begin
         lane_in = start_lane;
         len_in  = start_len + LEN_WIDTH'(count_sat);
         f1_block_in = tail_bytes;
      end
      f1_block_in[WORD_WIDTH-1 -: LEN_WIDTH] = len_in;
      f1_lane_in = lane_in;
   end

   // Finalization: block absorb and lane-two flip, then four rounds, then fold
   always_comb begin
      f2_lane_in = sip_absorb(f1_lane_ff, f1_block_ff);
      f2_lane_in.lane_two = f2_lane_in.lane_two ^ FINAL_XOR;
      f3_lane_in = sip_two_rounds(f2_lane_ff);
      rsp_hash_in = '0;
      begin
         sip24_lanes_type fin;
         fin = sip_two_rounds(f3_lane_ff);
         rsp_hash_in = fin.lane_zero ^ fin.lane_one ^ fin.lane_two ^ fin.lane_three;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         s0_valid_ff  <= 1'b0;
         in_msg_ff    <= 1'b0;
         len_ff       <= '0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // write key registers
         if (csr_valid) begin
            unique case (sip24_csr_type'(csr_index))
               CSR_KEY_LOW:  key_low_ff  <= csr_data;
               CSR_KEY_HIGH: key_high_ff <= csr_data;
               default: ;
            endcase
         end

         if (req_valid && s0_ready) begin
            s0_valid_ff <= 1'b1;
         end else if (s0_fire) begin
            s0_valid_ff <= 1'b0;
         end

         // advance message state; a last word ends the message
         if (s0_fire) begin
            len_ff    <= len_in;
            in_msg_ff <= !s0_last_ff;
         end

         if (f1_ready) begin
            f1_valid_ff <= s0_fire && s0_last_ff;
         end
         if (f2_ready) begin
            f2_valid_ff <= f1_valid_ff;
         end
         if (f3_ready) begin
            f3_valid_ff <= f2_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= f3_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && s0_ready) begin
         s0_word_ff  <= req_message_word;
         s0_count_ff <= req_byte_count;
         s0_last_ff  <= req_last;
      end
      if (s0_fire) begin
         lane_ff <= lane_in;
      end
      if (f1_ready) begin
         f1_lane_ff  <= f1_lane_in;
         f1_block_ff <= f1_block_in;
      end
      if (f2_ready) begin
         f2_lane_ff <= f2_lane_in;
      end
      if (f3_ready) begin
         f3_lane_ff <= f3_lane_in;
      end
      if (out_ready) begin
         rsp_hash_ff <= rsp_hash_in;
      end
   end

   // Checks
   a_msg_open: assert property (@(posedge clock) disable iff (reset)
      s0_fire && !s0_last_ff |=> in_msg_ff)
      else $error("message not open after a non-last request");

   a_last_to_final: assert property (@(posedge clock) disable iff (reset)
      s0_fire && s0_last_ff |=> f1_valid_ff && !in_msg_ff)
      else $error("last request did not enter finalization");

   a_f1_hold: assert property (@(posedge clock) disable iff (reset)
      f1_valid_ff && !f2_ready |=> f1_valid_ff && $stable(f1_block_ff))
      else $error("finalization stage lost data while stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> req_ready)
      else $error("empty request register refused a request");

endmodule

// ----- test/siphash_2_4_stream_tb.sv -----
// Self-checking testbench for the SipHash-2-4 stream hasher with a built-in hash predictor.
module siphash_2_4_stream_tb
   import sip24_pkg::*;
();

   localparam int unsigned HALF_PERIOD     = 6;
   localparam int unsigned RESET_CYCLES    = 7;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned ITEMS_PER_PHASE = 280;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned REPORT_LIMIT    = 10;

   // Track keys and lane state, predict hashes and compare them in order
   class siphash_predictor;
      logic [WORD_WIDTH-1:0] key_half[2];
      logic [WORD_WIDTH-1:0] lane[4];
      logic [LEN_WIDTH-1:0]  byte_total;
      bit                    open_msg;
      logic [WORD_WIDTH-1:0] expected_hashes[$];
      int unsigned           mismatches;

      function new();
         key_half[0] = '0;
         key_half[1] = '0;
         lane = '{default: '0};
         byte_total = '0;
         open_msg = 1'b0;
         mismatches = 0;
      endfunction

      function void set_key(sip24_csr_type idx, logic [WORD_WIDTH-1:0] value);
         key_half[idx] = value;
      endfunction

      function logic [WORD_WIDTH-1:0] rol(logic [WORD_WIDTH-1:0] x, int unsigned r);
         return (x << r) | (x >> (WORD_WIDTH - r));
      endfunction

      function void mix_round();
         lane[0] = lane[0] + lane[1];
         lane[1] = rol(lane[1], ROT_A) ^ lane[0];
         lane[0] = rol(lane[0], ROT_B);
         lane[2] = lane[2] + lane[3];
         lane[3] = rol(lane[3], ROT_C) ^ lane[2];
         lane[0] = lane[0] + lane[3];
         lane[3] = rol(lane[3], ROT_D) ^ lane[0];
         lane[2] = lane[2] + lane[1];
         lane[1] = rol(lane[1], ROT_E) ^ lane[2];
         lane[2] = rol(lane[2], ROT_B);
      endfunction

      function void absorb_block(logic [WORD_WIDTH-1:0] m);
         lane[3] = lane[3] ^ m;
         mix_round();
         mix_round();
         lane[0] = lane[0] ^ m;
      endfunction

      // Advance the lanes for one accepted request; queue a hash on the last one
      function void note_request(logic [WORD_WIDTH-1:0] word,
                                 logic [COUNT_WIDTH-1:0] count, bit last);
         int unsigned           n;
         logic [WORD_WIDTH-1:0] tail;
         // keys are sampled only when a message starts
         if (!open_msg) begin
            lane[0] = SIP_C0 ^ key_half[CSR_KEY_LOW];
            lane[1] = SIP_C1 ^ key_half[CSR_KEY_HIGH];
            lane[2] = SIP_C2 ^ key_half[CSR_KEY_LOW];
            lane[3] = SIP_C3 ^ key_half[CSR_KEY_HIGH];
            byte_total = '0;
            open_msg = 1'b1;
         end
         if (!last) begin
            absorb_block(word);
            byte_total = byte_total + LEN_WIDTH'(BYTES_PER_WORD);
            return;
         end
         // saturate oversized counts to a full word
         n = (count > BYTES_PER_WORD) ? BYTES_PER_WORD : int'(count);
         if (n == BYTES_PER_WORD) begin
            absorb_block(word);
            byte_total = byte_total + LEN_WIDTH'(BYTES_PER_WORD);
            tail = '0;
         end else begin
            tail = word & ((64'd1 << (8 * n)) - 64'd1);
            byte_total = byte_total + LEN_WIDTH'(n);
         end
         tail = tail | (WORD_WIDTH'(byte_total) << LEN_SHIFT);
         absorb_block(tail);
         lane[2] = lane[2] ^ FINAL_XOR;
         repeat (4) mix_round();
         expected_hashes.push_back(lane[0] ^ lane[1] ^ lane[2] ^ lane[3]);
         open_msg = 1'b0;
      endfunction

      // Compare one delivered hash with the oldest prediction
      function void check_hash(logic [WORD_WIDTH-1:0] actual);
         logic [WORD_WIDTH-1:0] predicted;
         if (expected_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected hash %h with nothing pending", actual);
            return;
         end
         predicted = expected_hashes.pop_front();
         if (predicted !== actual) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("hash mismatch: expected %h, got %h", predicted, actual);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [WORD_WIDTH-1:0]    req_message_word = '0;
   logic [COUNT_WIDTH-1:0]   req_byte_count = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [WORD_WIDTH-1:0]    rsp_hash_value;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   sip24_csr_type            csr_index = CSR_KEY_LOW;
   logic [WORD_WIDTH-1:0]    csr_data = '0;

   siphash_predictor sb = new();
   int unsigned      send_idle_pct = 19;
   int unsigned      recv_idle_pct = 51;
   int unsigned      items_sent = 0;
   int unsigned      cycle_count = 0;

   siphash_2_4_stream DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_byte_count   (req_byte_count),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Check each hash that will be taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_hash(rsp_hash_value);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [WORD_WIDTH-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(19);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [WORD_WIDTH-1:0] word,
                               input logic [COUNT_WIDTH-1:0] count, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_byte_count   <= count;
      req_last         <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sb.note_request(word, count, last);
      items_sent++;
   endtask

   // Hold off requests until every hash has come out and the pipeline is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keys(input logic [WORD_WIDTH-1:0] low_half,
                             input logic [WORD_WIDTH-1:0] high_half);
      sip24_csr_type         idx;
      logic [WORD_WIDTH-1:0] value;
      for (int i = 0; i < 2; i++) begin
         idx   = (i == 0) ? CSR_KEY_LOW : CSR_KEY_HIGH;
         value = (i == 0) ? low_half : high_half;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= value;
         @(negedge clock);
         while (!csr_ready) @(negedge clock);
         @(posedge clock);
         sb.set_key(idx, value);
      end
      csr_valid <= 1'b0;
   endtask

   // Drain, rekey, then stream random messages; a few are long enough to wrap the length
   task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
                            input logic [WORD_WIDTH-1:0] low_half,
                            input logic [WORD_WIDTH-1:0] high_half);
      int unsigned            target;
      int unsigned            words;
      int unsigned            pick;
      logic [COUNT_WIDTH-1:0] count;
      wait_drained();
      write_keys(low_half, high_half);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 60)
            words = $urandom_range(1, 3);
         else if (pick < 90)
            words = $urandom_range(4, 8);
         else
            words = $urandom_range(20, 40);
         for (int i = 1; i < words; i++)
            send_request(random_word(), COUNT_WIDTH'($urandom_range(0, 15)), 1'b0);
         if ($urandom_range(3) == 0)
            count = COUNT_WIDTH'($urandom_range(9, 15));
         else
            count = COUNT_WIDTH'($urandom_range(0, 8));
         send_request(random_word(), count, 1'b1);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty message under the reset keys, unused bytes random
      send_request(random_word(), COUNT_WIDTH'(0), 1'b1);

      wait_drained();
      write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
      // fifteen-byte message with junk in the unused top byte
      send_request(64'h0706050403020100, COUNT_WIDTH'(0), 1'b0);
      send_request(64'hff0e0d0c0b0a0908, COUNT_WIDTH'(7), 1'b1);
      // full last word, then oversized counts that saturate
      send_request('1, FULL_COUNT, 1'b1);
      send_request('0, COUNT_WIDTH'(15), 1'b1);
      send_request(random_word(), COUNT_WIDTH'(9), 1'b1);
      // counts on non-last words are ignored
      send_request(random_word(), COUNT_WIDTH'(15), 1'b0);
      send_request('1, COUNT_WIDTH'(3), 1'b0);
      send_request(random_word(), COUNT_WIDTH'(3), 1'b1);
      send_request('0, COUNT_WIDTH'(1), 1'b1);
      send_request('1, COUNT_WIDTH'(7), 1'b1);
      for (int c = 2; c <= 6; c++)
         send_request(random_word(), COUNT_WIDTH'(c), 1'b1);
      // rekey mid-message: the open message keeps its old keys
      send_request(random_word(), FULL_COUNT, 1'b0);
      wait_drained();
      write_keys('1, '0);
      send_request(random_word(), COUNT_WIDTH'(5), 1'b1);

      run_phase(19, 51, '1, '1);
      run_phase(51, 19, random_word(), random_word());
      run_phase(0, 0, '0, '1);

      wait_drained();
      if (sb.mismatches == 0 && sb.expected_hashes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/sip24_pkg.sv
rtl/siphash_2_4_stream.sv
test/siphash_2_4_stream_tb.sv
